[rtl/core/fcd_pkg.sv]
// Shared constants, types and helper functions for the formal context derivation unit.
package fcd_pkg;

    // Relation geometry
    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CFG_W    = 7;
    localparam int RES_W    = 64;
    localparam int SET_W    = 64;
    localparam int ROWIX_W  = 6;
    localparam int CMD_W    = 2;

    // Transaction commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_UP    = 2'd1,
        CMD_DOWN  = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Sequencer to accumulator control
    typedef struct packed {
        logic             start;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             deliver;
    } acc_ctrl_t;

    // Clamp the configured size into 1..MAX_SIZE
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] r;
        r = n;
        if (n == '0)
            r = CFG_W'(1);
        else if (n > CFG_W'(MAX_SIZE))
            r = CFG_W'(MAX_SIZE);
        return r;
    endfunction

    // Low n bits set
    function automatic logic [MAX_SIZE-1:0] width_mask(input logic [CFG_W-1:0] n);
        logic [MAX_SIZE-1:0] m;
        for (int i = 0; i < MAX_SIZE; i++)
            m[i] = (CFG_W'(i) < n);
        return m;
    endfunction

endpackage

[rtl/core/fcd_ram.sv]
// Generic single-port-write, registered-read RAM.
module fcd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/fcd_seq.sv]
// Sequencer: walks the stored rows one per cycle for each query transaction.
module fcd_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [fcd_pkg::CMD_W-1:0]         command,
    input  logic [fcd_pkg::CFG_W-1:0]         active_size,
    input  logic                              slot_free,
    output logic                              in_ready,
    output logic                              rd_en,
    output logic [fcd_pkg::IDX_W-1:0]         rd_addr,
    output logic [fcd_pkg::CFG_W-1:0]         size_eff,
    output fcd_pkg::acc_ctrl_t                ctrl
);

    fcd_pkg::state_t                 state_reg, state_next;
    logic [fcd_pkg::IDX_W-1:0]       cnt_reg, cnt_next;
    logic [fcd_pkg::CFG_W-1:0]       n_reg, n_next;
    logic                            proc_valid_reg;
    logic [fcd_pkg::IDX_W-1:0]       proc_idx_reg;
    logic                            query_acc;
    logic                            last_row;

    assign size_eff  = fcd_pkg::eff_size(active_size);
    assign query_acc = in_valid && (state_reg == fcd_pkg::ST_IDLE)
                       && (fcd_pkg::cmd_t'(command) != fcd_pkg::CMD_LOAD);
    assign last_row  = (fcd_pkg::CFG_W'(cnt_reg) == (n_reg - fcd_pkg::CFG_W'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        case (state_reg)
            fcd_pkg::ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = fcd_pkg::ST_SCAN;
                    cnt_next   = '0;
                    n_next     = size_eff;
                end
            end
            fcd_pkg::ST_SCAN:
            begin
                if (last_row)
                    state_next = fcd_pkg::ST_DRAIN;
                else
                    cnt_next = cnt_reg + fcd_pkg::IDX_W'(1);
            end
            fcd_pkg::ST_DRAIN:
                state_next = fcd_pkg::ST_FINISH;
            fcd_pkg::ST_FINISH:
            begin
                if (slot_free)
                    state_next = fcd_pkg::ST_IDLE;
            end
            default:
                state_next = fcd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = (state_reg == fcd_pkg::ST_IDLE);
        rd_en        = (state_reg == fcd_pkg::ST_SCAN);
        rd_addr      = cnt_reg;
        ctrl.start   = query_acc;
        ctrl.step    = proc_valid_reg;
        ctrl.idx     = proc_idx_reg;
        ctrl.deliver = (state_reg == fcd_pkg::ST_FINISH) && slot_free;
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fcd_pkg::ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= fcd_pkg::CFG_W'(fcd_pkg::MAX_SIZE);
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            proc_valid_reg <= rd_en;
            proc_idx_reg   <= cnt_reg;
        end
    end

    // Scan never addresses a row past the active size
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcd_pkg::ST_SCAN) |-> (fcd_pkg::CFG_W'(cnt_reg) < n_reg))
        else $error("scan counter beyond active size");

    // A query transaction blocks the input until its result is handed off
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !in_ready)
        else $error("input ready right after query accept");

endmodule

[rtl/core/fcd_acc.sv]
// Shared subset-compare and AND/OR accumulate unit plus the result register.
module fcd_acc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fcd_pkg::acc_ctrl_t                 ctrl,
    input  logic [fcd_pkg::CMD_W-1:0]          command,
    input  logic [fcd_pkg::SET_W-1:0]          set_bits,
    input  logic [fcd_pkg::CFG_W-1:0]          size_eff,
    input  logic [fcd_pkg::MAX_SIZE-1:0]       row,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [fcd_pkg::RES_W-1:0]          result_set
);

    fcd_pkg::cmd_t                   cmd_reg;
    logic [fcd_pkg::MAX_SIZE-1:0]    q_reg;
    logic [fcd_pkg::MAX_SIZE-1:0]    mask_reg;
    logic [fcd_pkg::MAX_SIZE-1:0]    acc_reg, acc_next;
    logic [fcd_pkg::MAX_SIZE-1:0]    start_mask;
    logic                            out_valid_reg;
    logic [fcd_pkg::RES_W-1:0]       result_reg;
    logic                            contains;
    logic                            take;

    assign start_mask = fcd_pkg::width_mask(size_eff);

    // One subset test per row
    assign contains = ((q_reg & ~row) == '0);
    assign take     = (cmd_reg == fcd_pkg::CMD_UP) ? q_reg[ctrl.idx] : contains;

    // Accumulator update
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.start)
        begin
            if (fcd_pkg::cmd_t'(command) == fcd_pkg::CMD_DOWN)
                acc_next = '0;
            else
                acc_next = '1;
        end
        else if (ctrl.step)
        begin
            if (cmd_reg == fcd_pkg::CMD_DOWN)
                acc_next[ctrl.idx] = contains;
            else if (take)
                acc_next = acc_reg & row;
        end
    end

    // Query operands and accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            cmd_reg  <= fcd_pkg::cmd_t'(command);
            q_reg    <= set_bits[fcd_pkg::MAX_SIZE-1:0] & start_mask;
            mask_reg <= start_mask;
        end
        acc_reg <= acc_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.deliver)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.deliver)
            result_reg <= fcd_pkg::RES_W'(acc_reg & mask_reg);
    end

    assign out_valid  = out_valid_reg;
    assign result_set = result_reg;

    // Result bits above the active size are always clear
    a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((result_reg[fcd_pkg::MAX_SIZE-1:0] & ~mask_reg) == '0))
        else $error("result has bits above active size");

endmodule

[rtl/core/formal_context_derivation_unit.sv]
// Top level of the formal context derivation unit: config, row store and glue.
// Load: the row is written at the accepting edge, no result.
// Query: the n rows (n = clamped active size) are read from the row RAM, one stored row
//   per cycle; the next transaction waits until the result is in the output register.
// Reset: active size 64, every row reads as zero through per-row valid flags,
//   no clearing pass; the block is ready as soon as reset is released.
module formal_context_derivation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcd_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fcd_pkg::CMD_W-1:0]           command,
    input  logic [fcd_pkg::ROWIX_W-1:0]         row_index,
    input  logic [fcd_pkg::SET_W-1:0]           set_bits,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fcd_pkg::RES_W-1:0]           result_set
);

    logic [fcd_pkg::CFG_W-1:0]       active_size_reg;
    logic [fcd_pkg::MAX_SIZE-1:0]    row_valid_reg;
    logic                            row_hit_reg;
    logic                            wr_en;
    logic                            load_ok;
    logic                            rd_en;
    logic [fcd_pkg::IDX_W-1:0]       rd_addr;
    logic [fcd_pkg::IDX_W-1:0]       wr_addr;
    logic [fcd_pkg::MAX_SIZE-1:0]    rd_data;
    logic [fcd_pkg::MAX_SIZE-1:0]    row;
    logic [fcd_pkg::CFG_W-1:0]       size_eff;
    logic                            slot_free;
    fcd_pkg::acc_ctrl_t              ctrl;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_size_reg <= fcd_pkg::CFG_W'(64);
        else if (cfg_valid && cfg_ready)
            active_size_reg <= cfg_data;
    end

    // Row load decode
    assign load_ok = (fcd_pkg::CFG_W'(row_index) < fcd_pkg::CFG_W'(fcd_pkg::MAX_SIZE));
    assign wr_en   = in_valid && in_ready && load_ok
                     && (fcd_pkg::cmd_t'(command) == fcd_pkg::CMD_LOAD);
    assign wr_addr = row_index[fcd_pkg::IDX_W-1:0];

    // Per-row written flags; unwritten rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (wr_en)
            row_valid_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_hit_reg <= 1'b0;
        else if (rd_en)
            row_hit_reg <= row_valid_reg[rd_addr];
    end

    assign row = row_hit_reg ? rd_data : '0;

    // Output slot can take a new result
    assign slot_free = !out_valid || out_ready;

    fcd_ram #(
        .WIDTH (fcd_pkg::MAX_SIZE),
        .DEPTH (fcd_pkg::MAX_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (set_bits[fcd_pkg::MAX_SIZE-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fcd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .command     (command),
        .active_size (active_size_reg),
        .slot_free   (slot_free),
        .in_ready    (in_ready),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .size_eff    (size_eff),
        .ctrl        (ctrl)
    );

    fcd_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .command    (command),
        .set_bits   (set_bits),
        .size_eff   (size_eff),
        .row        (row),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_set (result_set)
    );

    // A loaded row is marked written on the next cycle
    a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> row_valid_reg[$past(wr_addr)])
        else $error("loaded row not marked as written");

endmodule
